@@ sv/mtt_pkg.sv @@
// Shared constants for the motion trajectory tracer.
// Fixed field widths, fixed-point format, register and item codes.
// No dependencies.
package mtt_pkg;

    localparam int VEC_W   = 16;            // one motion component, signed Q8.8
    localparam int WORD_W  = 2 * VEC_W;     // store word: y in high half, x in low half
    localparam int FRAC_W  = 8;
    localparam int ACC_W   = 22;            // up to 32 summed components
    localparam int POS_W   = 24;            // col*256 + 128 +/- accumulator
    localparam int Q_W     = POS_W - FRAC_W;
    localparam int COORD_W = 10;
    localparam int SRC_W   = 20;
    localparam int SLOT_W  = 5;
    localparam int STEP_CAP = 32;

    localparam int CFG_W_W  = 11;
    localparam int CFG_H_W  = 11;
    localparam int CFG_S_W  = 6;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [FRAC_W-1:0] HALF_Q = 8'd128;

    localparam logic [1:0] REG_FIELD_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FIELD_HEIGHT = 2'd1;
    localparam logic [1:0] REG_INTERP_STEPS = 2'd2;

    localparam logic [CFG_W_W-1:0] FIELD_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_H_W-1:0] FIELD_HEIGHT_RST = 11'd1024;
    localparam logic [CFG_S_W-1:0] INTERP_STEPS_RST = 6'd10;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_TRACE = 1'b1;

endpackage

@@ sv/mtt_store_ram.sv @@
// Motion vector store: simple dual-port synchronous RAM, one write and one read port.
// Read data is registered and holds while no read is issued. Uses mtt_pkg.
module mtt_store_ram #(
    parameter int DEPTH = 1048576,
    parameter int AW    = 20
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [mtt_pkg::WORD_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [mtt_pkg::WORD_W-1:0] rdata
);
    import mtt_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/motion_trajectory_tracer.sv @@
// Motion trajectory tracer top level: APB registers, trace sequencer, output register.
// Traces past and future trajectories through a motion field held in mtt_store_ram.
// Depends on mtt_pkg and mtt_store_ram.
//
//  channel   handshake                 payload
//  -------   -----------------------   ----------------------------------------------
//  input     in_valid / in_ready       kind, col, row, shift_x, shift_y
//  output    out_valid / out_ready     past_slot/valid/source, future_slot/valid/source,
//                                      last
//  config    APB psel/penable/pwrite   paddr, pwdata, prdata, pready (always high)
//
// An in-range load is written to the store when accepted. A trace fetches the destination
// vector, then takes each step through calc, address and accumulate phases, set by the single
// store read port that serves the past and the future lookup of each step in turn.
// rst_n clears control state and registers; store contents are undefined until loaded.
// A full output register stalls the sequencer at the end of a step; in_ready is high
// only while no trace is running.
module motion_trajectory_tracer #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_STEPS  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mtt_pkg::PADDR_W-1:0]  paddr,
    input  logic [mtt_pkg::PDATA_W-1:0]  pwdata,
    output logic [mtt_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic [mtt_pkg::COORD_W-1:0]  col,
    input  logic [mtt_pkg::COORD_W-1:0]  row,
    input  logic signed [mtt_pkg::VEC_W-1:0] shift_x,
    input  logic signed [mtt_pkg::VEC_W-1:0] shift_y,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mtt_pkg::SLOT_W-1:0]   past_slot,
    output logic                         past_valid,
    output logic [mtt_pkg::SRC_W-1:0]    past_source,
    output logic [mtt_pkg::SLOT_W-1:0]   future_slot,
    output logic                         future_valid,
    output logic [mtt_pkg::SRC_W-1:0]    future_source,
    output logic                         last
);
    import mtt_pkg::*;

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = $clog2(DEPTH);
    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(MAX_HEIGHT + 1);
    localparam int PROD_W  = YW + WW + 1;
    localparam int STEP_HI = (MAX_STEPS < STEP_CAP) ? MAX_STEPS : STEP_CAP;
    localparam logic [AW-1:0] MW_A = AW'(MAX_WIDTH);

    typedef enum logic [1:0] {ST_IDLE, ST_ORIG, ST_RUN} state_t;
    typedef enum logic [1:0] {PH_CALC_P, PH_ADDR_P, PH_ACC_P} phase_t;

    // configuration
    logic [CFG_W_W-1:0] field_width_reg;
    logic [CFG_H_W-1:0] field_height_reg;
    logic [CFG_S_W-1:0] interp_steps_reg;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;

    // control
    state_t      state_reg;
    phase_t      phase_reg;
    logic [SLOT_W-1:0] step_reg;
    logic        adv;
    logic        in_take;
    logic        take_load;
    logic        take_trace;
    logic        step_end;
    logic        is_last;

    // trace context
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic [WW-1:0]      w_reg;
    logic [HW-1:0]      h_reg;
    logic [SLOT_W-1:0]  len_reg;
    logic               dest_ok_reg;
    logic [WORD_W-1:0]  orig_word_reg;
    logic signed [ACC_W-1:0] dx_p_reg;
    logic signed [ACC_W-1:0] dy_p_reg;
    logic signed [ACC_W-1:0] dx_f_reg;
    logic signed [ACC_W-1:0] dy_f_reg;

    // position stage
    logic [XW-1:0] calc_ix_reg;
    logic [YW-1:0] calc_iy_reg;
    logic          calc_ok_reg;
    logic          acc_ok_reg;
    logic          past_ok_reg;
    logic [SRC_W-1:0] past_src_reg;

    // output register
    logic              out_valid_reg;
    logic [SLOT_W-1:0] past_slot_reg;
    logic              past_valid_reg;
    logic [SRC_W-1:0]  past_source_reg;
    logic [SLOT_W-1:0] future_slot_reg;
    logic              future_valid_reg;
    logic [SRC_W-1:0]  future_source_reg;
    logic              last_reg;

    // store ports
    logic              st_we;
    logic [AW-1:0]     st_waddr;
    logic [WORD_W-1:0] st_wdata;
    logic              st_re;
    logic [AW-1:0]     st_raddr;
    logic [WORD_W-1:0] st_rdata;

    // ---------------------------------------------------------------- APB
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        case (cfg_idx)
            REG_FIELD_WIDTH:  prdata = PDATA_W'(field_width_reg);
            REG_FIELD_HEIGHT: prdata = PDATA_W'(field_height_reg);
            REG_INTERP_STEPS: prdata = PDATA_W'(interp_steps_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg  <= FIELD_WIDTH_RST;
            field_height_reg <= FIELD_HEIGHT_RST;
            interp_steps_reg <= INTERP_STEPS_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_FIELD_WIDTH:  field_width_reg  <= pwdata[CFG_W_W-1:0];
                REG_FIELD_HEIGHT: field_height_reg <= pwdata[CFG_H_W-1:0];
                REG_INTERP_STEPS: interp_steps_reg <= pwdata[CFG_S_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------- clamps
    logic [WW-1:0]     w_clamp;
    logic [HW-1:0]     h_clamp;
    logic [SLOT_W-1:0] len_clamp;

    always_comb
    begin
        if (field_width_reg == '0)
            w_clamp = WW'(1);
        else if (32'(field_width_reg) > MAX_WIDTH)
            w_clamp = WW'(MAX_WIDTH);
        else
            w_clamp = WW'(field_width_reg);

        if (field_height_reg == '0)
            h_clamp = HW'(1);
        else if (32'(field_height_reg) > MAX_HEIGHT)
            h_clamp = HW'(MAX_HEIGHT);
        else
            h_clamp = HW'(field_height_reg);

        if (interp_steps_reg < CFG_S_W'(2))
            len_clamp = SLOT_W'(1);
        else if (32'(interp_steps_reg) > STEP_HI)
            len_clamp = SLOT_W'(STEP_HI - 1);
        else
            len_clamp = SLOT_W'(interp_steps_reg - CFG_S_W'(1));
    end

    // ---------------------------------------------------------------- handshake
    assign in_ready   = (state_reg == ST_IDLE);
    assign in_take    = in_valid & in_ready;
    assign take_load  = in_take & (kind == KIND_LOAD);
    assign take_trace = in_take & (kind == KIND_TRACE);

    logic in_store;
    assign in_store = (32'(col) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT);

    // hold the sequencer when a finished step has nowhere to go
    assign adv      = !((phase_reg == PH_ACC_P) && out_valid_reg && !out_ready);
    assign step_end = (state_reg == ST_RUN) && (phase_reg == PH_ACC_P) && adv;
    assign is_last  = (step_reg == len_reg - SLOT_W'(1));

    // ---------------------------------------------------------------- position calc
    logic signed [POS_W-1:0] base_x;
    logic signed [POS_W-1:0] base_y;
    logic signed [POS_W-1:0] off_x;
    logic signed [POS_W-1:0] off_y;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [POS_W-1:0] mag_x;
    logic [POS_W-1:0] mag_y;
    logic [Q_W-1:0]   q_x;
    logic [Q_W-1:0]   q_y;
    logic             ok_new;

    assign base_x = POS_W'({col_reg, HALF_Q});
    assign base_y = POS_W'({row_reg, HALF_Q});

    always_comb
    begin
        // past moves against the field, future with it
        if (phase_reg == PH_CALC_P)
        begin
            off_x = -POS_W'(dx_p_reg);
            off_y = -POS_W'(dy_p_reg);
        end
        else
        begin
            off_x = POS_W'(dx_f_reg);
            off_y = POS_W'(dy_f_reg);
        end
        pos_x = base_x + off_x;
        pos_y = base_y + off_y;
        mag_x = pos_x[POS_W-1] ? POS_W'(-pos_x) : POS_W'(pos_x);
        mag_y = pos_y[POS_W-1] ? POS_W'(-pos_y) : POS_W'(pos_y);
        q_x   = mag_x[POS_W-1:FRAC_W];
        q_y   = mag_y[POS_W-1:FRAC_W];
        ok_new = !(pos_x[POS_W-1] && (q_x != '0)) && !(pos_y[POS_W-1] && (q_y != '0))
                 && (32'(q_x) < 32'(w_reg)) && (32'(q_y) < 32'(h_reg));
    end

    // ---------------------------------------------------------------- address / source
    logic [PROD_W-1:0] src_full;
    logic [SRC_W-1:0]  src_new;

    assign src_full = PROD_W'(calc_iy_reg) * PROD_W'(w_reg) + PROD_W'(calc_ix_reg);
    assign src_new  = calc_ok_reg ? SRC_W'(src_full) : '0;

    // ---------------------------------------------------------------- accumulate
    logic [WORD_W-1:0]       vec_word;
    logic signed [ACC_W-1:0] vec_x;
    logic signed [ACC_W-1:0] vec_y;

    assign vec_word = acc_ok_reg ? st_rdata : orig_word_reg;
    assign vec_x    = ACC_W'($signed(vec_word[VEC_W-1:0]));
    assign vec_y    = ACC_W'($signed(vec_word[WORD_W-1:VEC_W]));

    // ---------------------------------------------------------------- store ports
    always_comb
    begin
        st_we    = take_load & in_store;
        st_waddr = AW'(row) * MW_A + AW'(col);
        st_wdata = {shift_y, shift_x};
        st_re    = 1'b0;
        st_raddr = AW'(calc_iy_reg) * MW_A + AW'(calc_ix_reg);
        if (state_reg == ST_IDLE)
        begin
            st_re    = take_trace & in_store;
            st_raddr = st_waddr;
        end
        else if ((state_reg == ST_RUN) && adv && calc_ok_reg
                 && ((phase_reg == PH_ADDR_P) || (phase_reg == PH_ACC_P)))
        begin
            st_re = 1'b1;
        end
    end

    mtt_store_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // ---------------------------------------------------------------- control + outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            phase_reg         <= PH_CALC_P;
            step_reg          <= '0;
            out_valid_reg     <= 1'b0;
            past_slot_reg     <= '0;
            past_valid_reg    <= 1'b0;
            past_source_reg   <= '0;
            future_slot_reg   <= '0;
            future_valid_reg  <= 1'b0;
            future_source_reg <= '0;
            last_reg          <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (take_trace)
                    begin
                        state_reg <= ST_ORIG;
                    end
                end
                ST_ORIG:
                begin
                    state_reg <= ST_RUN;
                    phase_reg <= PH_CALC_P;
                    step_reg  <= '0;
                end
                ST_RUN:
                begin
                    if (adv)
                    begin
                        case (phase_reg)
                            PH_CALC_P: phase_reg <= PH_ADDR_P;
                            PH_ADDR_P: phase_reg <= PH_ACC_P;
                            default:   phase_reg <= PH_CALC_P;
                        endcase
                    end
                    if (step_end)
                    begin
                        out_valid_reg     <= 1'b1;
                        past_slot_reg     <= step_reg;
                        past_valid_reg    <= past_ok_reg;
                        past_source_reg   <= past_src_reg;
                        future_slot_reg   <= len_reg - SLOT_W'(1) - step_reg;
                        future_valid_reg  <= calc_ok_reg;
                        future_source_reg <= src_new;
                        last_reg          <= is_last;
                        step_reg          <= step_reg + SLOT_W'(1);
                        if (is_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        if (take_trace)
        begin
            col_reg     <= col;
            row_reg     <= row;
            w_reg       <= w_clamp;
            h_reg       <= h_clamp;
            len_reg     <= len_clamp;
            dest_ok_reg <= in_store;
        end
        if (state_reg == ST_ORIG)
        begin
            orig_word_reg <= dest_ok_reg ? st_rdata : '0;
            dx_p_reg <= dest_ok_reg ? ACC_W'($signed(st_rdata[VEC_W-1:0])) : '0;
            dx_f_reg <= dest_ok_reg ? ACC_W'($signed(st_rdata[VEC_W-1:0])) : '0;
            dy_p_reg <= dest_ok_reg ? ACC_W'($signed(st_rdata[WORD_W-1:VEC_W])) : '0;
            dy_f_reg <= dest_ok_reg ? ACC_W'($signed(st_rdata[WORD_W-1:VEC_W])) : '0;
        end
        if ((state_reg == ST_RUN) && adv)
        begin
            case (phase_reg)
                PH_CALC_P:
                begin
                    calc_ix_reg <= XW'(q_x);
                    calc_iy_reg <= YW'(q_y);
                    calc_ok_reg <= ok_new;
                    // finish the future lookup of the previous step
                    if (step_reg != '0)
                    begin
                        dx_f_reg <= dx_f_reg + vec_x;
                        dy_f_reg <= dy_f_reg + vec_y;
                    end
                end
                PH_ADDR_P:
                begin
                    past_ok_reg  <= calc_ok_reg;
                    past_src_reg <= src_new;
                    acc_ok_reg   <= calc_ok_reg;
                    calc_ix_reg  <= XW'(q_x);
                    calc_iy_reg  <= YW'(q_y);
                    calc_ok_reg  <= ok_new;
                end
                default:
                begin
                    dx_p_reg   <= dx_p_reg + vec_x;
                    dy_p_reg   <= dy_p_reg + vec_y;
                    acc_ok_reg <= calc_ok_reg;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign past_slot     = past_slot_reg;
    assign past_valid    = past_valid_reg;
    assign past_source   = past_source_reg;
    assign future_slot   = future_slot_reg;
    assign future_valid  = future_valid_reg;
    assign future_source = future_source_reg;
    assign last          = last_reg;

endmodule
